// ----- hdl/xypf_pkg.sv -----
package xypf_pkg;

  localparam int unsigned DATA_W     = 16;
  localparam int unsigned ERR_W      = DATA_W + 1;
  localparam int unsigned DIFF_W     = DATA_W + 2;
  localparam int unsigned GAIN_W     = 16;
  localparam int unsigned RATE_W     = 10;
  localparam int unsigned GAIN_FRAC  = 12;
  localparam int unsigned PER_FRAC   = 16;
  localparam int unsigned SUM_W      = 32;
  localparam int unsigned DER_W      = DIFF_W + RATE_W;
  localparam int unsigned MUL_A_W    = SUM_W;
  localparam int unsigned MUL_B_W    = GAIN_W + 1;
  localparam int unsigned PROD_W     = MUL_A_W + MUL_B_W;
  localparam int unsigned ACC_W      = 40;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned IN_W       = 8 * DATA_W;
  localparam int unsigned OUT_W      = 3 * DATA_W;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_PROP    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INTEG   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DERIV   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HEADING = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RATE    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD  = 3'd5;

  typedef enum logic [8:0] {
    ST_IDLE  = 9'b000000001,
    ST_ERR   = 9'b000000010,
    ST_DIFF  = 9'b000000100,
    ST_PROP  = 9'b000001000,
    ST_DERIV = 9'b000010000,
    ST_INTEG = 9'b000100000,
    ST_INCR  = 9'b001000000,
    ST_UPD   = 9'b010000000,
    ST_DONE  = 9'b100000000
  } state_e;

  typedef struct packed {
    state_e st;
    logic   load;
    logic   first;
  } ctl_t;

  typedef struct packed {
    logic [GAIN_W-1:0] kp;
    logic [GAIN_W-1:0] ki;
    logic [GAIN_W-1:0] kd;
    logic [GAIN_W-1:0] period;
    logic [RATE_W-1:0] rate;
  } gain_t;

  function automatic logic signed [DATA_W-1:0] sat_data(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] hi;
    logic signed [ACC_W-1:0] lo;
    hi = ACC_W'(signed'({1'b0, {(DATA_W-1){1'b1}}}));
    lo = ACC_W'(signed'({1'b1, {(DATA_W-1){1'b0}}}));
    if (v > hi) return hi[DATA_W-1:0];
    else if (v < lo) return lo[DATA_W-1:0];
    else return v[DATA_W-1:0];
  endfunction

  function automatic logic signed [SUM_W-1:0] sat_sum(input logic signed [SUM_W:0] v);
    if (v[SUM_W] != v[SUM_W-1]) return {v[SUM_W], {(SUM_W-1){~v[SUM_W]}}};
    else return v[SUM_W-1:0];
  endfunction

endpackage

// ----- hdl/xypf_lane.sv -----
module xypf_lane (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  xypf_pkg::ctl_t                      ctl_i,
  input  xypf_pkg::gain_t                     gain_i,
  input  logic signed [xypf_pkg::DATA_W-1:0]  meas_i,
  input  logic signed [xypf_pkg::DATA_W-1:0]  tgt_i,
  input  logic signed [xypf_pkg::DATA_W-1:0]  ff_i,
  output logic signed [xypf_pkg::ACC_W-1:0]   res_o
);

  logic signed [xypf_pkg::DATA_W-1:0]  meas_q, tgt_q, ff_q;
  logic signed [xypf_pkg::ERR_W-1:0]   err_q, prev_q, err_new;
  logic signed [xypf_pkg::DIFF_W-1:0]  diff;
  logic signed [xypf_pkg::SUM_W-1:0]   sum_q;
  logic signed [xypf_pkg::SUM_W:0]     sum_ext;
  logic signed [xypf_pkg::DER_W-1:0]   der_q;
  logic signed [xypf_pkg::ACC_W-1:0]   acc_q, acc_d, term;
  logic signed [xypf_pkg::MUL_A_W-1:0] mul_a;
  logic signed [xypf_pkg::MUL_B_W-1:0] mul_b;
  logic signed [xypf_pkg::PROD_W-1:0]  prod, prod_q;

  assign err_new = xypf_pkg::ERR_W'(tgt_q) - xypf_pkg::ERR_W'(meas_q);
  assign diff    = xypf_pkg::DIFF_W'(err_q) - xypf_pkg::DIFF_W'(prev_q);
  assign term    = xypf_pkg::ACC_W'(prod_q >>> xypf_pkg::GAIN_FRAC);
  assign sum_ext = (xypf_pkg::SUM_W+1)'(sum_q)
                 + (xypf_pkg::SUM_W+1)'(prod_q >>> xypf_pkg::PER_FRAC);

  // one shared multiplier, operands picked by sequencer step
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (ctl_i.st)
      xypf_pkg::ST_DIFF: begin
        mul_a = xypf_pkg::MUL_A_W'(diff);
        mul_b = signed'({7'd0, gain_i.rate});
      end
      xypf_pkg::ST_PROP: begin
        mul_a = xypf_pkg::MUL_A_W'(err_q);
        mul_b = signed'({1'b0, gain_i.kp});
      end
      xypf_pkg::ST_DERIV: begin
        mul_a = xypf_pkg::MUL_A_W'(der_q);
        mul_b = signed'({1'b0, gain_i.kd});
      end
      xypf_pkg::ST_INTEG: begin
        mul_a = sum_q;
        mul_b = signed'({1'b0, gain_i.ki});
      end
      xypf_pkg::ST_INCR: begin
        mul_a = xypf_pkg::MUL_A_W'(err_q);
        mul_b = signed'({1'b0, gain_i.period});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = xypf_pkg::PROD_W'(mul_a) * xypf_pkg::PROD_W'(mul_b);

  always_comb begin
    acc_d = acc_q;
    unique case (ctl_i.st)
      xypf_pkg::ST_PROP:  acc_d = xypf_pkg::ACC_W'(ff_q);
      xypf_pkg::ST_DERIV: acc_d = acc_q + term;
      xypf_pkg::ST_INTEG: acc_d = acc_q + term;
      xypf_pkg::ST_INCR:  acc_d = acc_q + term;
      default:            acc_d = acc_q;
    endcase
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      meas_q <= meas_i;
      tgt_q  <= tgt_i;
      ff_q   <= ff_i;
    end
    if (ctl_i.st == xypf_pkg::ST_ERR) err_q <= err_new;
    if (ctl_i.st == xypf_pkg::ST_PROP) der_q <= prod_q[xypf_pkg::DER_W-1:0];
    prod_q <= prod;
    acc_q  <= acc_d;
  end

  // loop state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= '0;
      sum_q  <= '0;
    end else begin
      if (ctl_i.st == xypf_pkg::ST_ERR && ctl_i.first) begin
        prev_q <= err_new;
        sum_q  <= '0;
      end else if (ctl_i.st == xypf_pkg::ST_UPD) begin
        prev_q <= err_q;
        sum_q  <= xypf_pkg::sat_sum(sum_ext);
      end
    end
  end

  assign res_o = acc_q;

endmodule

// ----- hdl/xypf_merge.sv -----
module xypf_merge (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               load_i,
  input  logic signed [xypf_pkg::ACC_W-1:0]  res_x_i,
  input  logic signed [xypf_pkg::ACC_W-1:0]  res_y_i,
  input  logic signed [xypf_pkg::ACC_W-1:0]  res_yaw_i,
  output logic                               free_o,
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  output logic [xypf_pkg::OUT_W-1:0]         m_axis_tdata_o
);

  logic                        valid_q;
  logic [xypf_pkg::OUT_W-1:0]  data_q;

  assign free_o = !valid_q || m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      valid_q <= 1'b0;
    end
  end

  // yaw lane yields +P, the command is its negation
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= {xypf_pkg::sat_data(-res_yaw_i),
                 xypf_pkg::sat_data(res_y_i),
                 xypf_pkg::sat_data(res_x_i)};
    end
  end

  assign m_axis_tvalid_o = valid_q;
  assign m_axis_tdata_o  = data_q;

endmodule

// ----- hdl/xy_position_pid_with_feedforward_top.sv -----
// Two-axis position PID with velocity feedforward and a proportional heading
// loop. One input beat is one control tick; it yields one output beat holding
// cmd_vx, cmd_vy and cmd_yaw_rate, each saturated to 16 bits signed Q8.8.
// Three identical lanes (x, y, yaw) run side by side, each with one shared
// 32x17 multiplier stepped through error, derivative, P, D, I and integral
// update; a merge stage saturates, negates the yaw term and holds the result.
// From input accept to output valid a tick passes through the error step,
// the five multiplies of each lane's sequencer, the update step and the
// hand-over to the output register. The next beat is taken in the cycle after
// the hand-over, so no beat is accepted before the previous tick is through,
// even while the previous result still waits in the output register; a result
// that finds the output register still full holds the lanes in their last
// step. The user must write gains through cfg_we_i/cfg_idx_i/cfg_data_i only
// while the block is idle; the block itself does not enforce it. Indexes 0..5
// are prop, integ, deriv, heading gain, tick rate, tick period, others are
// dropped. The first tick after reset zeroes the D term and the integral.
module xy_position_pid_with_feedforward_top (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // meas_x, meas_y, target_x, target_y, ff_vx, ff_vy, yaw_meas, yaw_target
  input  logic [xypf_pkg::IN_W-1:0]            s_axis_tdata_i,
  input  logic                                 s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  // cmd_vx, cmd_vy, cmd_yaw_rate
  output logic [xypf_pkg::OUT_W-1:0]           m_axis_tdata_o,
  output logic                                 m_axis_tvalid_o,
  input  logic                                 m_axis_tready_i,
  input  logic                                 cfg_we_i,
  input  logic [xypf_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [xypf_pkg::GAIN_W-1:0]          cfg_data_i
);

  localparam int unsigned DW = xypf_pkg::DATA_W;

  xypf_pkg::state_e state_q, state_d;
  logic             first_q;
  logic             in_acc;
  logic             merge_free, merge_load;
  xypf_pkg::ctl_t   ctl;

  logic [xypf_pkg::GAIN_W-1:0] prop_q, integ_q, deriv_q, heading_q, period_q;
  logic [xypf_pkg::RATE_W-1:0] rate_q;

  xypf_pkg::gain_t gain_pos, gain_yaw;

  logic signed [xypf_pkg::ACC_W-1:0] res_x, res_y, res_yaw;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prop_q    <= 16'd819;
      integ_q   <= '0;
      deriv_q   <= '0;
      heading_q <= 16'd2048;
      rate_q    <= 10'd10;
      period_q  <= 16'd6554;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        xypf_pkg::REG_PROP:    prop_q    <= cfg_data_i;
        xypf_pkg::REG_INTEG:   integ_q   <= cfg_data_i;
        xypf_pkg::REG_DERIV:   deriv_q   <= cfg_data_i;
        xypf_pkg::REG_HEADING: heading_q <= cfg_data_i;
        xypf_pkg::REG_RATE:    rate_q    <= cfg_data_i[xypf_pkg::RATE_W-1:0];
        xypf_pkg::REG_PERIOD:  period_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // sequencer shared by all lanes
  assign s_axis_tready_o = (state_q == xypf_pkg::ST_IDLE);
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign merge_load      = (state_q == xypf_pkg::ST_DONE) && merge_free;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      xypf_pkg::ST_IDLE:  if (in_acc) state_d = xypf_pkg::ST_ERR;
      xypf_pkg::ST_ERR:   state_d = xypf_pkg::ST_DIFF;
      xypf_pkg::ST_DIFF:  state_d = xypf_pkg::ST_PROP;
      xypf_pkg::ST_PROP:  state_d = xypf_pkg::ST_DERIV;
      xypf_pkg::ST_DERIV: state_d = xypf_pkg::ST_INTEG;
      xypf_pkg::ST_INTEG: state_d = xypf_pkg::ST_INCR;
      xypf_pkg::ST_INCR:  state_d = xypf_pkg::ST_UPD;
      xypf_pkg::ST_UPD:   state_d = xypf_pkg::ST_DONE;
      xypf_pkg::ST_DONE:  if (merge_free) state_d = xypf_pkg::ST_IDLE;
      default:            state_d = xypf_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= xypf_pkg::ST_IDLE;
      first_q <= 1'b1;
    end else begin
      state_q <= state_d;
      if (state_q == xypf_pkg::ST_ERR) first_q <= 1'b0;
    end
  end

  assign ctl = '{st: state_q, load: in_acc, first: first_q};

  assign gain_pos = '{kp: prop_q, ki: integ_q, kd: deriv_q, period: period_q, rate: rate_q};
  // yaw lane: P only
  assign gain_yaw = '{kp: heading_q, ki: '0, kd: '0, period: period_q, rate: rate_q};

  xypf_lane u_lane_x (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (ctl),
    .gain_i (gain_pos),
    .meas_i (s_axis_tdata_i[0*DW +: DW]),
    .tgt_i  (s_axis_tdata_i[2*DW +: DW]),
    .ff_i   (s_axis_tdata_i[4*DW +: DW]),
    .res_o  (res_x)
  );

  xypf_lane u_lane_y (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (ctl),
    .gain_i (gain_pos),
    .meas_i (s_axis_tdata_i[1*DW +: DW]),
    .tgt_i  (s_axis_tdata_i[3*DW +: DW]),
    .ff_i   (s_axis_tdata_i[5*DW +: DW]),
    .res_o  (res_y)
  );

  xypf_lane u_lane_yaw (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (ctl),
    .gain_i (gain_yaw),
    .meas_i (s_axis_tdata_i[6*DW +: DW]),
    .tgt_i  (s_axis_tdata_i[7*DW +: DW]),
    .ff_i   ('0),
    .res_o  (res_yaw)
  );

  xypf_merge u_merge (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .load_i          (merge_load),
    .res_x_i         (res_x),
    .res_y_i         (res_y),
    .res_yaw_i       (res_yaw),
    .free_o          (merge_free),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  // checks
  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q)) else $error("sequencer state not one-hot");

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> state_q == xypf_pkg::ST_ERR) else $error("accepted beat did not start a tick");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    merge_load |-> (!m_axis_tvalid_o || m_axis_tready_i))
    else $error("result overwritten while waiting");

  a_first_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(first_q) |-> $past(state_q) == xypf_pkg::ST_ERR)
    else $error("first-tick flag dropped outside error step");

endmodule
